// ===== hdl/sfb_pkg.sv =====
// Package for the stuffed frame builder: queue entry type, configuration
// type, register indexes and reset values. No dependencies.
package sfb_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_FLAG    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTROL = 3'd4;

    localparam logic [7:0] RST_FLAG    = 8'h7E;
    localparam logic [7:0] RST_ESCAPE  = 8'h7D;
    localparam logic [7:0] RST_MASK    = 8'h20;
    localparam logic [7:0] RST_ADDRESS = 8'h03;
    localparam logic [7:0] RST_CONTROL = 8'h03;

    typedef struct packed {
        logic [7:0] flag_value;
        logic [7:0] escape_value;
        logic [7:0] toggle_mask;
        logic [7:0] address_value;
        logic [7:0] control_value;
    } t_cfg;

    // one classified item: header needed, frame end, raw byte, parity so far
    typedef struct packed {
        logic       hdr;
        logic       last;
        logic [7:0] data;
        logic [7:0] parity;
    } t_entry;

endpackage

// ===== hdl/sfb_front.sv =====
// Front end of the stuffed frame builder: accepts items, tracks frame
// position and running parity, and builds queue entries. Uses sfb_pkg.
module sfb_front import sfb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic       i_full,
    input  logic [7:0] i_payload_byte,
    input  logic       i_ends_frame,
    output logic       o_wr,
    output t_entry     o_entry
);

    logic       r_inside;
    logic [7:0] r_parity;
    logic       n_inside;
    logic [7:0] n_parity;
    logic [7:0] par_now;

    assign o_wr    = i_push && !i_full;
    assign par_now = (r_inside ? r_parity : 8'h00) ^ i_payload_byte;

    always_comb begin
        o_entry.hdr    = !r_inside;
        o_entry.last   = i_ends_frame;
        o_entry.data   = i_payload_byte;
        o_entry.parity = par_now;
    end

    always_comb begin
        n_inside = r_inside;
        n_parity = r_parity;
        if (o_wr) begin
            n_inside = !i_ends_frame;
            n_parity = i_ends_frame ? 8'h00 : par_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside <= 1'b0;
            r_parity <= 8'h00;
        end else begin
            r_inside <= n_inside;
            r_parity <= n_parity;
        end
    end

endmodule

// ===== hdl/sfb_queue.sv =====
// Short queue of classified entries between front and back ends.
// Uses sfb_pkg for the entry type.
module sfb_queue import sfb_pkg::*; #(
    parameter int P_DEPTH = QUEUE_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_wr,
    input  t_entry i_entry,
    input  logic   i_rd,
    output t_entry o_head,
    output logic   o_valid,
    output logic   o_full
);

    localparam int PTR_W = $clog2(P_DEPTH);
    localparam int CNT_W = $clog2(P_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(P_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(P_DEPTH);

    t_entry            r_mem [P_DEPTH];
    logic [PTR_W-1:0]  r_wptr, n_wptr;
    logic [PTR_W-1:0]  r_rptr, n_rptr;
    logic [CNT_W-1:0]  r_cnt,  n_cnt;

    assign o_head  = r_mem[r_rptr];
    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == CNT_FULL);

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (i_wr) begin
            n_wptr = (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
        end
        if (i_rd) begin
            n_rptr = (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
        end
        if (i_wr && !i_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_wr && i_rd) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr |-> (r_cnt != CNT_FULL))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd |-> (r_cnt != '0))
        else $error("queue read while empty");

endmodule

// ===== hdl/sfb_back.sv =====
// Back end of the stuffed frame builder: walks each entry through header (at frame
// start), stuffed data, and at frame end parity and closing flag, one byte per cycle
// into an output register while it is empty or popped. Uses sfb_pkg.
module sfb_back import sfb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  t_entry     i_head,
    input  logic       i_head_valid,
    output logic       o_rd,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [7:0] o_line_byte,
    output logic       o_run_last,
    output logic       o_frame_done
);

    typedef enum logic [8:0] {
        ST_FLAG  = 9'b000000001,
        ST_ADDR  = 9'b000000010,
        ST_CTRL  = 9'b000000100,
        ST_HXOR  = 9'b000001000,
        ST_DATA  = 9'b000010000,
        ST_DXOR  = 9'b000100000,
        ST_PAR   = 9'b001000000,
        ST_PXOR  = 9'b010000000,
        ST_CLOSE = 9'b100000000
    } t_step;

    t_step      r_step, n_step, cur_step;
    logic       r_busy, n_busy;
    logic       r_ovalid, n_ovalid;
    logic [7:0] r_obyte;
    logic       r_olast, r_odone;

    logic       adv;
    logic       d_stuff, p_stuff;
    logic [7:0] emit_byte;
    logic       emit_done;   // last byte for this entry
    logic       emit_close;

    assign adv      = i_head_valid && (!r_ovalid || i_pop);
    assign cur_step = r_busy ? r_step : (i_head.hdr ? ST_FLAG : ST_DATA);
    assign d_stuff  = (i_head.data == i_cfg.flag_value) ||
                      (i_head.data == i_cfg.escape_value);
    assign p_stuff  = (i_head.parity == i_cfg.flag_value) ||
                      (i_head.parity == i_cfg.escape_value);

    always_comb begin
        emit_byte  = i_cfg.flag_value;
        emit_done  = 1'b0;
        emit_close = 1'b0;
        n_step     = cur_step;
        case (cur_step)
            ST_FLAG: begin
                emit_byte = i_cfg.flag_value;
                n_step    = ST_ADDR;
            end
            ST_ADDR: begin
                emit_byte = i_cfg.address_value;
                n_step    = ST_CTRL;
            end
            ST_CTRL: begin
                emit_byte = i_cfg.control_value;
                n_step    = ST_HXOR;
            end
            ST_HXOR: begin
                emit_byte = i_cfg.address_value ^ i_cfg.control_value;
                n_step    = ST_DATA;
            end
            ST_DATA: begin
                if (d_stuff) begin
                    emit_byte = i_cfg.escape_value;
                    n_step    = ST_DXOR;
                end else begin
                    emit_byte = i_head.data;
                    n_step    = ST_PAR;
                    emit_done = !i_head.last;
                end
            end
            ST_DXOR: begin
                emit_byte = i_head.data ^ i_cfg.toggle_mask;
                n_step    = ST_PAR;
                emit_done = !i_head.last;
            end
            ST_PAR: begin
                if (p_stuff) begin
                    emit_byte = i_cfg.escape_value;
                    n_step    = ST_PXOR;
                end else begin
                    emit_byte = i_head.parity;
                    n_step    = ST_CLOSE;
                end
            end
            ST_PXOR: begin
                emit_byte = i_head.parity ^ i_cfg.toggle_mask;
                n_step    = ST_CLOSE;
            end
            ST_CLOSE: begin
                emit_byte  = i_cfg.flag_value;
                emit_done  = 1'b1;
                emit_close = 1'b1;
                n_step     = ST_FLAG;
            end
            default: begin
                emit_byte  = i_cfg.flag_value;
                emit_done  = 1'b1;
                n_step     = ST_FLAG;
            end
        endcase
    end

    assign o_rd = adv && emit_done;

    always_comb begin
        n_busy   = r_busy;
        n_ovalid = r_ovalid;
        if (i_pop && r_ovalid) begin
            n_ovalid = 1'b0;
        end
        if (adv) begin
            n_ovalid = 1'b1;
            n_busy   = !emit_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_step   <= ST_FLAG;
            r_ovalid <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_ovalid <= n_ovalid;
            if (adv) begin
                r_step <= n_step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_obyte <= emit_byte;
            r_olast <= emit_done;
            r_odone <= emit_close;
        end
    end

    assign o_empty      = !r_ovalid;
    assign o_line_byte  = r_obyte;
    assign o_run_last   = r_olast;
    assign o_frame_done = r_odone;

    a_close_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_odone) |-> r_olast)
        else $error("closing flag not marked as last byte of item");

    a_busy_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> i_head_valid)
        else $error("sequencer mid-entry with no entry queued");

endmodule

// ===== hdl/stuffed_frame_builder.sv =====
// With the back end idle, an accepted item is written into the queue memory and
// its first byte then goes through the back-end output register to the ports.
// The back end puts out one line byte per cycle while its output is free or
// popped; an item makes 1 to 9 line bytes (header 4, stuffed byte 1-2, on frame
// end stuffed parity 1-2 plus closing flag), emitted by the back-end sequencer.
// Reset (synchronous, active low) empties the queue, restarts outside a frame
// and loads the default flag, escape, mask, address and control values.
module stuffed_frame_builder import sfb_pkg::*; #(
    parameter int P_QUEUE_DEPTH = QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [7:0]           i_payload_byte,
    input  logic                 i_ends_frame,
    output logic                 empty,
    input  logic                 pop,
    output logic [7:0]           o_line_byte,
    output logic                 o_run_last,
    output logic                 o_frame_done,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data
);

    t_cfg   r_cfg;
    t_entry wr_entry, head;
    logic   wr, rd, head_valid;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flag_value    <= RST_FLAG;
            r_cfg.escape_value  <= RST_ESCAPE;
            r_cfg.toggle_mask   <= RST_MASK;
            r_cfg.address_value <= RST_ADDRESS;
            r_cfg.control_value <= RST_CONTROL;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_FLAG:    r_cfg.flag_value    <= i_cfg_data;
                CFG_ESCAPE:  r_cfg.escape_value  <= i_cfg_data;
                CFG_MASK:    r_cfg.toggle_mask   <= i_cfg_data;
                CFG_ADDRESS: r_cfg.address_value <= i_cfg_data;
                CFG_CONTROL: r_cfg.control_value <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    sfb_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_full         (full),
        .i_payload_byte (i_payload_byte),
        .i_ends_frame   (i_ends_frame),
        .o_wr           (wr),
        .o_entry        (wr_entry)
    );

    sfb_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_entry (wr_entry),
        .i_rd    (rd),
        .o_head  (head),
        .o_valid (head_valid),
        .o_full  (full)
    );

    sfb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head       (head),
        .i_head_valid (head_valid),
        .o_rd         (rd),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_line_byte  (o_line_byte),
        .o_run_last   (o_run_last),
        .o_frame_done (o_frame_done)
    );

endmodule
